@@ rtl/core/minmax_trace_decimator_top_macros.svh @@
// Assertion macros used by the checker of the min/max trace decimator.
// Holds macro definitions only; no dependencies.
`ifndef MINMAX_TRACE_DECIMATOR_TOP_MACROS_SVH
`define MINMAX_TRACE_DECIMATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define MTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtd check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define MTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtd check failed");

`endif

@@ rtl/core/mtd_pkg.sv @@
// Package of the min/max trace decimator: widths, codes, reset values and types.
// No dependencies; the RTL modules of the block refer to it by scoped names.
package mtd_pkg;

    // Field and datapath widths
    localparam int SAMPLE_BITS    = 8;
    localparam int COLUMN_BITS    = 13;
    localparam int ACC_BITS       = 40;
    localparam int FRAC_BITS      = 16;
    localparam int IPART_BITS     = ACC_BITS - FRAC_BITS;
    localparam int STEP_BITS      = 25;
    localparam int INDEX_BITS     = 24;
    localparam int BASE_BITS      = 10;
    localparam int SCALE_BITS     = 24;
    localparam int OFFSET_BITS    = 10;
    localparam int SCREEN_BITS    = 13;
    localparam int ROW_BITS       = 11;
    localparam int CONN_BITS      = 2;
    localparam int PROD_BITS      = SAMPLE_BITS + SCALE_BITS + 1;
    localparam int ROWSUM_BITS    = PROD_BITS + 1;
    localparam int COLSUM_BITS    = ((COLUMN_BITS > SCREEN_BITS) ? COLUMN_BITS : SCREEN_BITS) + 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 25;

    // Saturation limits
    localparam logic [SCREEN_BITS-1:0]     SCREEN_MAX = '1;
    localparam logic signed [ROW_BITS-1:0] ROW_MIN    = {1'b1, {(ROW_BITS-1){1'b0}}};
    localparam logic signed [ROW_BITS-1:0] ROW_MAX    = {1'b0, {(ROW_BITS-1){1'b1}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_POSITION = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_BASELINE     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT           = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_SCALE        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_MIN        = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_MAX        = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_OFFSET    = 3'd7;

    // Result kinds
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_MARK   = 1'b1;

    // Connector codes
    localparam logic [CONN_BITS-1:0] CONN_NONE    = 2'd0;
    localparam logic [CONN_BITS-1:0] CONN_RISING  = 2'd1;
    localparam logic [CONN_BITS-1:0] CONN_FALLING = 2'd2;

    // Configuration reset values
    localparam logic [STEP_BITS-1:0]          PHASE_STEP_RST    = 25'd65536;
    localparam logic [INDEX_BITS-1:0]         TRIGGER_POS_RST   = 24'd0;
    localparam logic [BASE_BITS-1:0]          ROW_BASELINE_RST  = 10'd148;
    localparam logic                          INVERT_RST        = 1'b0;
    localparam logic [SCALE_BITS-1:0]         ROW_SCALE_RST     = 24'd66052;
    localparam logic signed [SAMPLE_BITS-1:0] RANGE_MIN_RST     = -8'sd127;
    localparam logic signed [SAMPLE_BITS-1:0] RANGE_MAX_RST     = 8'sd127;
    localparam logic [OFFSET_BITS-1:0]        COLUMN_OFFSET_RST = 10'd10;

    // Configuration register set
    typedef struct packed {
        logic [STEP_BITS-1:0]          phase_step;
        logic [INDEX_BITS-1:0]         trigger_position;
        logic [BASE_BITS-1:0]          row_baseline;
        logic                          invert;
        logic [SCALE_BITS-1:0]         row_scale;
        logic signed [SAMPLE_BITS-1:0] range_min;
        logic signed [SAMPLE_BITS-1:0] range_max;
        logic [OFFSET_BITS-1:0]        column_offset;
    } cfg_t;

    // Column or mark event leaving the accumulator stage
    typedef struct packed {
        logic                          kind;
        logic [SCREEN_BITS-1:0]        screen_column;
        logic signed [SAMPLE_BITS-1:0] run_min;
        logic signed [SAMPLE_BITS-1:0] run_max;
        logic                          has_prev;
        logic                          trig;
    } event_t;

    // Event with scaled extremes, leaving the multiplier stage
    typedef struct packed {
        logic                        kind;
        logic [SCREEN_BITS-1:0]      screen_column;
        logic signed [PROD_BITS-1:0] prod_min;
        logic signed [PROD_BITS-1:0] prod_max;
        logic                        has_prev;
        logic                        trig;
    } prod_t;

endpackage

@@ rtl/core/mtd_cfg.sv @@
// Configuration register file of the min/max trace decimator.
// Depends on mtd_pkg for the register indexes, reset values and cfg_t.
module mtd_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mtd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mtd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output mtd_pkg::cfg_t                        cfg
);

    mtd_pkg::cfg_t cfg_reg;

    // Always ready: a write is taken whenever cfg_valid is high
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step       <= mtd_pkg::PHASE_STEP_RST;
            cfg_reg.trigger_position <= mtd_pkg::TRIGGER_POS_RST;
            cfg_reg.row_baseline     <= mtd_pkg::ROW_BASELINE_RST;
            cfg_reg.invert           <= mtd_pkg::INVERT_RST;
            cfg_reg.row_scale        <= mtd_pkg::ROW_SCALE_RST;
            cfg_reg.range_min        <= mtd_pkg::RANGE_MIN_RST;
            cfg_reg.range_max        <= mtd_pkg::RANGE_MAX_RST;
            cfg_reg.column_offset    <= mtd_pkg::COLUMN_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mtd_pkg::CFG_PHASE_STEP:
                    cfg_reg.phase_step <= cfg_data[mtd_pkg::STEP_BITS-1:0];
                mtd_pkg::CFG_TRIGGER_POSITION:
                    cfg_reg.trigger_position <= cfg_data[mtd_pkg::INDEX_BITS-1:0];
                mtd_pkg::CFG_ROW_BASELINE:
                    cfg_reg.row_baseline <= cfg_data[mtd_pkg::BASE_BITS-1:0];
                mtd_pkg::CFG_INVERT:
                    cfg_reg.invert <= cfg_data[0];
                mtd_pkg::CFG_ROW_SCALE:
                    cfg_reg.row_scale <= cfg_data[mtd_pkg::SCALE_BITS-1:0];
                mtd_pkg::CFG_RANGE_MIN:
                    cfg_reg.range_min <= cfg_data[mtd_pkg::SAMPLE_BITS-1:0];
                mtd_pkg::CFG_RANGE_MAX:
                    cfg_reg.range_max <= cfg_data[mtd_pkg::SAMPLE_BITS-1:0];
                mtd_pkg::CFG_COLUMN_OFFSET:
                    cfg_reg.column_offset <= cfg_data[mtd_pkg::OFFSET_BITS-1:0];
            endcase
        end
    end

endmodule

@@ rtl/core/mtd_front.sv @@
// Accumulator stage: sample clamp, running min/max, phase accumulator, column
// and trigger decisions, and the event register. Depends on mtd_pkg.
module mtd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mtd_pkg::cfg_t                        cfg,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [mtd_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic [mtd_pkg::INDEX_BITS-1:0]       sample_index,
    input  logic                                 sweep_start,
    input  logic                                 sweep_end,
    output logic                                 ev_valid,
    input  logic                                 ev_ready,
    output mtd_pkg::event_t                      ev
);

    typedef logic [mtd_pkg::COLSUM_BITS-1:0] colsum_t;

    logic signed [mtd_pkg::SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic signed [mtd_pkg::SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic [mtd_pkg::ACC_BITS-1:0]           acc_reg, acc_next;
    logic [mtd_pkg::COLUMN_BITS-1:0]        col_reg, col_next;
    logic                                   prev_valid_reg, prev_valid_next;
    logic                                   trig_done_reg, trig_done_next;
    logic                                   ev_valid_reg, ev_valid_next;
    mtd_pkg::event_t                        ev_reg, ev_next;

    logic                                   accept, ev_load;
    logic signed [mtd_pkg::SAMPLE_BITS-1:0] rmin, rmax, base_max, base_min;
    logic signed [mtd_pkg::SAMPLE_BITS-1:0] v_lo, v_clamp, new_max, new_min;
    logic [mtd_pkg::ACC_BITS-1:0]           acc_base, acc_new;
    logic [mtd_pkg::ACC_BITS:0]             acc_sum;
    logic [mtd_pkg::IPART_BITS-1:0]         ipart;
    logic [mtd_pkg::COLUMN_BITS-1:0]        col_base, col_new;
    logic                                   pv_base, td_base;
    logic                                   emit_col, emit_mark, trig_col;
    colsum_t                                col_sum;
    logic [mtd_pkg::SCREEN_BITS-1:0]        screen;

    // Handshake: the event register frees up when empty or when passed on
    assign ev_load      = !ev_valid_reg || ev_ready;
    assign sample_stall = !ev_load;
    assign accept       = sample_valid && !sample_stall;
    assign ev_valid     = ev_valid_reg;
    assign ev           = ev_reg;

    // Sweep start clears the running state ahead of the sample
    always_comb
    begin
        rmin     = cfg.range_min;
        rmax     = cfg.range_max;
        base_max = sweep_start ? rmin : run_max_reg;
        base_min = sweep_start ? rmax : run_min_reg;
        acc_base = sweep_start ? '0 : acc_reg;
        col_base = sweep_start ? '0 : col_reg;
        pv_base  = sweep_start ? 1'b0 : prev_valid_reg;
        td_base  = sweep_start ? 1'b0 : trig_done_reg;
    end

    // Clamp (upper bound last, so it wins on an inverted range) and fold
    always_comb
    begin
        v_lo    = (sample_value < rmin) ? rmin : sample_value;
        v_clamp = (v_lo > rmax) ? rmax : v_lo;
        new_max = (v_clamp > base_max) ? v_clamp : base_max;
        new_min = (v_clamp < base_min) ? v_clamp : base_min;
    end

    // Saturating phase accumulator and column index
    always_comb
    begin
        acc_sum = {1'b0, acc_base}
                + {{(mtd_pkg::ACC_BITS + 1 - mtd_pkg::STEP_BITS){1'b0}}, cfg.phase_step};
        acc_new = acc_sum[mtd_pkg::ACC_BITS] ? '1 : acc_sum[mtd_pkg::ACC_BITS-1:0];
        ipart   = acc_new[mtd_pkg::ACC_BITS-1:mtd_pkg::FRAC_BITS];
        col_new = (|ipart[mtd_pkg::IPART_BITS-1:mtd_pkg::COLUMN_BITS]) ? '1
                : ipart[mtd_pkg::COLUMN_BITS-1:0];
    end

    // Column and trigger decisions
    always_comb
    begin
        emit_col  = col_new > col_base;
        trig_col  = !td_base && ((sample_index >= cfg.trigger_position) || sweep_end);
        emit_mark = !emit_col && sweep_end && !td_base;
        col_sum   = colsum_t'(col_base) + colsum_t'(cfg.column_offset);
        screen    = (col_sum > colsum_t'(mtd_pkg::SCREEN_MAX)) ? mtd_pkg::SCREEN_MAX
                  : col_sum[mtd_pkg::SCREEN_BITS-1:0];
    end

    // Next state and event
    always_comb
    begin
        acc_next = acc_new;
        if (emit_col)
        begin
            run_max_next    = rmin;
            run_min_next    = rmax;
            col_next        = col_new;
            prev_valid_next = 1'b1;
            trig_done_next  = td_base || trig_col;
        end
        else
        begin
            run_max_next    = new_max;
            run_min_next    = new_min;
            col_next        = col_base;
            prev_valid_next = pv_base;
            trig_done_next  = td_base || emit_mark;
        end
        ev_next.kind          = emit_col ? mtd_pkg::KIND_COLUMN : mtd_pkg::KIND_MARK;
        ev_next.screen_column = screen;
        ev_next.run_min       = new_min;
        ev_next.run_max       = new_max;
        ev_next.has_prev      = pv_base;
        ev_next.trig          = emit_col ? trig_col : 1'b1;
        ev_valid_next         = ev_load ? (accept && (emit_col || emit_mark)) : ev_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg    <= mtd_pkg::RANGE_MIN_RST;
            run_min_reg    <= mtd_pkg::RANGE_MAX_RST;
            acc_reg        <= '0;
            col_reg        <= '0;
            prev_valid_reg <= 1'b0;
            trig_done_reg  <= 1'b0;
            ev_valid_reg   <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= ev_valid_next;
            if (accept)
            begin
                run_max_reg    <= run_max_next;
                run_min_reg    <= run_min_next;
                acc_reg        <= acc_next;
                col_reg        <= col_next;
                prev_valid_reg <= prev_valid_next;
                trig_done_reg  <= trig_done_next;
            end
        end
    end

    // Event payload
    always_ff @(posedge clk)
    begin
        if (accept && ev_load)
        begin
            ev_reg <= ev_next;
        end
    end

endmodule

@@ rtl/core/mtd_scale.sv @@
// Multiplier stage: scales the column extremes by row_scale, one product each.
// Depends on mtd_pkg for event_t, prod_t and widths.
module mtd_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  mtd_pkg::cfg_t     cfg,
    input  logic              ev_valid,
    output logic              ev_ready,
    input  mtd_pkg::event_t   ev,
    output logic              pr_valid,
    input  logic              pr_ready,
    output mtd_pkg::prod_t    pr
);

    logic                                 pr_valid_reg;
    mtd_pkg::prod_t                       pr_reg, pr_next;
    logic                                 load;
    logic signed [mtd_pkg::PROD_BITS-1:0] min_ext, max_ext, scale_ext;

    // Handshake
    assign load     = !pr_valid_reg || pr_ready;
    assign ev_ready = load;
    assign pr_valid = pr_valid_reg;
    assign pr       = pr_reg;

    // Signed extremes times unsigned scale
    always_comb
    begin
        min_ext   = {{(mtd_pkg::PROD_BITS - mtd_pkg::SAMPLE_BITS){ev.run_min[mtd_pkg::SAMPLE_BITS-1]}},
                     ev.run_min};
        max_ext   = {{(mtd_pkg::PROD_BITS - mtd_pkg::SAMPLE_BITS){ev.run_max[mtd_pkg::SAMPLE_BITS-1]}},
                     ev.run_max};
        scale_ext = {{(mtd_pkg::PROD_BITS - mtd_pkg::SCALE_BITS){1'b0}}, cfg.row_scale};
        pr_next.kind          = ev.kind;
        pr_next.screen_column = ev.screen_column;
        pr_next.prod_min      = min_ext * scale_ext;
        pr_next.prod_max      = max_ext * scale_ext;
        pr_next.has_prev      = ev.has_prev;
        pr_next.trig          = ev.trig;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            pr_valid_reg <= ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ev_valid)
        begin
            pr_reg <= pr_next;
        end
    end

endmodule

@@ rtl/core/mtd_rowmap.sv @@
// Row stage: maps scaled extremes to screen rows, works out span and connector
// against the previous column, and holds the result register. Depends on mtd_pkg.
module mtd_rowmap (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mtd_pkg::cfg_t                          cfg,
    input  logic                                   pr_valid,
    output logic                                   pr_ready,
    input  mtd_pkg::prod_t                         pr,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic                                   result_kind,
    output logic [mtd_pkg::SCREEN_BITS-1:0]        screen_column,
    output logic signed [mtd_pkg::ROW_BITS-1:0]    lower_row,
    output logic signed [mtd_pkg::ROW_BITS-1:0]    upper_row,
    output logic                                   span_drawn,
    output logic [mtd_pkg::CONN_BITS-1:0]          connector,
    output logic signed [mtd_pkg::ROW_BITS-1:0]    connector_from_row,
    output logic                                   trigger_here
);

    // Baseline -/+ product, truncated toward zero, saturated to the row range
    function automatic logic signed [mtd_pkg::ROW_BITS-1:0] to_row(
        input logic signed [mtd_pkg::PROD_BITS-1:0] t,
        input logic [mtd_pkg::BASE_BITS-1:0]        base,
        input logic                                 inv
    );
        logic signed [mtd_pkg::ROWSUM_BITS-1:0]                    p_base, t_ext, p, p_adj;
        logic signed [mtd_pkg::ROWSUM_BITS-mtd_pkg::FRAC_BITS-1:0] r;
        logic signed [mtd_pkg::ROW_BITS-1:0]                       row;
        p_base = {{(mtd_pkg::ROWSUM_BITS - mtd_pkg::BASE_BITS - mtd_pkg::FRAC_BITS){1'b0}},
                  base, {mtd_pkg::FRAC_BITS{1'b0}}};
        t_ext  = {t[mtd_pkg::PROD_BITS-1], t};
        p      = inv ? (p_base + t_ext) : (p_base - t_ext);
        p_adj  = p[mtd_pkg::ROWSUM_BITS-1]
               ? (p + {{(mtd_pkg::ROWSUM_BITS - mtd_pkg::FRAC_BITS){1'b0}},
                       {mtd_pkg::FRAC_BITS{1'b1}}})
               : p;
        r      = p_adj[mtd_pkg::ROWSUM_BITS-1:mtd_pkg::FRAC_BITS];
        if (r < mtd_pkg::ROW_MIN)
        begin
            row = mtd_pkg::ROW_MIN;
        end
        else if (r > mtd_pkg::ROW_MAX)
        begin
            row = mtd_pkg::ROW_MAX;
        end
        else
        begin
            row = r[mtd_pkg::ROW_BITS-1:0];
        end
        return row;
    endfunction

    logic                                 valid_reg;
    logic                                 kind_reg, kind_next;
    logic [mtd_pkg::SCREEN_BITS-1:0]      col_reg;
    logic signed [mtd_pkg::ROW_BITS-1:0]  lower_reg, lower_next;
    logic signed [mtd_pkg::ROW_BITS-1:0]  upper_reg, upper_next;
    logic                                 span_reg, span_next;
    logic [mtd_pkg::CONN_BITS-1:0]        conn_reg, conn_next;
    logic signed [mtd_pkg::ROW_BITS-1:0]  from_reg, from_next;
    logic                                 trig_reg;
    logic signed [mtd_pkg::ROW_BITS-1:0]  prev_lower_reg, prev_upper_reg;
    logic signed [mtd_pkg::ROW_BITS-1:0]  lower_c, upper_c;
    logic                                 load, take, is_col;

    // Handshake: result register frees up when empty or taken
    assign load     = !valid_reg || !result_stall;
    assign pr_ready = load;
    assign take     = load && pr_valid;
    assign is_col   = (pr.kind == mtd_pkg::KIND_COLUMN);

    // Row mapping and connector
    always_comb
    begin
        lower_c   = to_row(pr.prod_min, cfg.row_baseline, cfg.invert);
        upper_c   = to_row(pr.prod_max, cfg.row_baseline, cfg.invert);
        kind_next = pr.kind;
        conn_next = mtd_pkg::CONN_NONE;
        from_next = '0;
        if (is_col)
        begin
            lower_next = lower_c;
            upper_next = upper_c;
            span_next  = (lower_c != upper_c);
            if (pr.has_prev)
            begin
                priority if (lower_c < prev_upper_reg)
                begin
                    conn_next = mtd_pkg::CONN_RISING;
                    from_next = prev_upper_reg;
                end
                else if ((upper_c > prev_lower_reg) || (lower_c == upper_c))
                begin
                    conn_next = mtd_pkg::CONN_FALLING;
                    from_next = prev_lower_reg;
                end
                else
                begin
                    conn_next = mtd_pkg::CONN_NONE;
                    from_next = '0;
                end
            end
        end
        else
        begin
            lower_next = '0;
            upper_next = '0;
            span_next  = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= pr_valid;
        end
    end

    // Result payload and previous column rows
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind_next;
            col_reg   <= pr.screen_column;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            span_reg  <= span_next;
            conn_reg  <= conn_next;
            from_reg  <= from_next;
            trig_reg  <= pr.trig;
            if (is_col)
            begin
                prev_lower_reg <= lower_c;
                prev_upper_reg <= upper_c;
            end
        end
    end

    assign result_valid       = valid_reg;
    assign result_kind        = kind_reg;
    assign screen_column      = col_reg;
    assign lower_row          = lower_reg;
    assign upper_row          = upper_reg;
    assign span_drawn         = span_reg;
    assign connector          = conn_reg;
    assign connector_from_row = from_reg;
    assign trigger_here       = trig_reg;

endmodule

@@ rtl/core/minmax_trace_decimator_top.sv @@
// Top level of the min/max trace decimator: configuration registers and the
// three-stage datapath. Depends on mtd_pkg, mtd_cfg, mtd_front, mtd_scale, mtd_rowmap.
//
// Takes one sample per clock while sample_stall is low and gives at most one
// result per sample. The sample transfer loads the event register, whose item
// then moves to the product register and on to the result register (three
// register stages); a result that shows leaves when result_stall is low. The
// rate is set by the update of the running min/max, phase
// accumulator and column counter, which every sample feeds back into; the
// row multipliers and row mapping sit in the two stages behind it. Each stage
// holds one item, so samples keep flowing while a result waits on a stalled
// output as long as a later stage has room. Configuration writes are always
// accepted; the user must make them only while idle: the block does not enforce it.
module minmax_trace_decimator_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mtd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mtd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [mtd_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic [mtd_pkg::INDEX_BITS-1:0]         sample_index,
    input  logic                                   sweep_start,
    input  logic                                   sweep_end,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic                                   result_kind,
    output logic [mtd_pkg::SCREEN_BITS-1:0]        screen_column,
    output logic signed [mtd_pkg::ROW_BITS-1:0]    lower_row,
    output logic signed [mtd_pkg::ROW_BITS-1:0]    upper_row,
    output logic                                   span_drawn,
    output logic [mtd_pkg::CONN_BITS-1:0]          connector,
    output logic signed [mtd_pkg::ROW_BITS-1:0]    connector_from_row,
    output logic                                   trigger_here
);

    mtd_pkg::cfg_t   cfg;
    mtd_pkg::event_t ev;
    mtd_pkg::prod_t  pr;
    logic            ev_valid, ev_ready, pr_valid, pr_ready;

    // Configuration registers
    mtd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Accumulator and decision stage
    mtd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .sample_index (sample_index),
        .sweep_start  (sweep_start),
        .sweep_end    (sweep_end),
        .ev_valid     (ev_valid),
        .ev_ready     (ev_ready),
        .ev           (ev)
    );

    // Multiplier stage
    mtd_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev),
        .pr_valid (pr_valid),
        .pr_ready (pr_ready),
        .pr       (pr)
    );

    // Row mapping and result register
    mtd_rowmap u_rowmap (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .pr_valid           (pr_valid),
        .pr_ready           (pr_ready),
        .pr                 (pr),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .result_kind        (result_kind),
        .screen_column      (screen_column),
        .lower_row          (lower_row),
        .upper_row          (upper_row),
        .span_drawn         (span_drawn),
        .connector          (connector),
        .connector_from_row (connector_from_row),
        .trigger_here       (trigger_here)
    );

endmodule

@@ rtl/core/mtd_checker.sv @@
// Port-level checker for the min/max trace decimator, bound to the top level.
// Depends on mtd_pkg and minmax_trace_decimator_top_macros.svh.
`include "minmax_trace_decimator_top_macros.svh"

module mtd_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   result_valid,
    input logic                                   result_stall,
    input logic                                   result_kind,
    input logic [mtd_pkg::SCREEN_BITS-1:0]        screen_column,
    input logic signed [mtd_pkg::ROW_BITS-1:0]    lower_row,
    input logic signed [mtd_pkg::ROW_BITS-1:0]    upper_row,
    input logic                                   span_drawn,
    input logic [mtd_pkg::CONN_BITS-1:0]          connector,
    input logic signed [mtd_pkg::ROW_BITS-1:0]    connector_from_row,
    input logic                                   trigger_here
);

    // A stalled result holds until its transfer
    `MTD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(screen_column) && $stable(lower_row) && $stable(upper_row) && $stable(trigger_here))

    // A trailing mark carries nothing but the column and the mark
    `MTD_ASSERT_NOW(a_mark_shape, clk, rst_n, result_valid && (result_kind == mtd_pkg::KIND_MARK), trigger_here && !span_drawn && (connector == mtd_pkg::CONN_NONE) && (lower_row == '0) && (upper_row == '0))

    // Span flag follows the two rows of a column result
    `MTD_ASSERT_NOW(a_span_rows, clk, rst_n, result_valid && (result_kind == mtd_pkg::KIND_COLUMN), span_drawn == (lower_row != upper_row))

    // Connector code is one of the three, and a NONE connector has a from-row of zero
    `MTD_ASSERT_NOW(a_conn_code, clk, rst_n, result_valid, ((connector == mtd_pkg::CONN_NONE) && (connector_from_row == '0)) || (connector == mtd_pkg::CONN_RISING) || (connector == mtd_pkg::CONN_FALLING))

endmodule

bind minmax_trace_decimator_top mtd_checker u_mtd_checker (.*);

@@ tb/sv/tb_minmax_trace_decimator_top.sv @@
// Self-checking testbench of minmax_trace_decimator_top: directed sweeps, then random traffic.
// Depends on mtd_pkg and the block's RTL; a local column/mark predictor checks every transfer.
module tb_minmax_trace_decimator_top;
    import mtd_pkg::*;

    localparam int LATENCY_SLACK = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 60;
    localparam logic [ACC_BITS-1:0]    ACC_SAT = '1;
    localparam logic [COLUMN_BITS-1:0] COL_SAT = '1;

    // One expected trace point: a column, or a mark on its own
    typedef struct {
        logic                       kind;
        logic [SCREEN_BITS-1:0]     column;
        logic signed [ROW_BITS-1:0] lower;
        logic signed [ROW_BITS-1:0] upper;
        logic                       span;
        logic [CONN_BITS-1:0]       conn;
        logic signed [ROW_BITS-1:0] from_row;
        logic                       trig;
    } trace_point_t;

    // Block ports
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample_value = '0;
    logic [INDEX_BITS-1:0]         sample_index = '0;
    logic                          sweep_start = 1'b0;
    logic                          sweep_end = 1'b0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic                          result_kind;
    logic [SCREEN_BITS-1:0]        screen_column;
    logic signed [ROW_BITS-1:0]    lower_row;
    logic signed [ROW_BITS-1:0]    upper_row;
    logic                          span_drawn;
    logic [CONN_BITS-1:0]          connector;
    logic signed [ROW_BITS-1:0]    connector_from_row;
    logic                          trigger_here;

    // Predictor state and register copy
    cfg_t                          shadow_cfg;
    logic signed [SAMPLE_BITS-1:0] run_max;
    logic signed [SAMPLE_BITS-1:0] run_min;
    logic [ACC_BITS-1:0]           phase_acc;
    logic [COLUMN_BITS-1:0]        cur_column;
    logic signed [ROW_BITS-1:0]    prev_lower;
    logic signed [ROW_BITS-1:0]    prev_upper;
    logic                          prev_valid;
    logic                          trig_done;
    trace_point_t                  pending_points[$];

    int send_idle_pct = 34;
    int recv_idle_pct = 48;
    int error_count   = 0;
    int cycle_count   = 0;

    minmax_trace_decimator_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .sample_value       (sample_value),
        .sample_index       (sample_index),
        .sweep_start        (sweep_start),
        .sweep_end          (sweep_end),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .result_kind        (result_kind),
        .screen_column      (screen_column),
        .lower_row          (lower_row),
        .upper_row          (upper_row),
        .span_drawn         (span_drawn),
        .connector          (connector),
        .connector_from_row (connector_from_row),
        .trigger_here       (trigger_here)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic cfg_t default_config();
        cfg_t c;
        c.phase_step       = PHASE_STEP_RST;
        c.trigger_position = TRIGGER_POS_RST;
        c.row_baseline     = ROW_BASELINE_RST;
        c.invert           = INVERT_RST;
        c.row_scale        = ROW_SCALE_RST;
        c.range_min        = RANGE_MIN_RST;
        c.range_max        = RANGE_MAX_RST;
        c.column_offset    = COLUMN_OFFSET_RST;
        return c;
    endfunction

    // Extremes -> screen row: baseline -/+ scaled value, truncated toward zero, saturated
    function automatic logic signed [ROW_BITS-1:0] map_row(input logic signed [SAMPLE_BITS-1:0] v);
        longint prod;
        longint pos;
        longint r;
        prod = longint'(v) * longint'({1'b0, shadow_cfg.row_scale});
        pos  = longint'({1'b0, shadow_cfg.row_baseline}) * 65536;
        pos  = shadow_cfg.invert ? pos + prod : pos - prod;
        r    = pos / 65536;
        if (r < -1024)
            r = -1024;
        if (r > 1023)
            r = 1023;
        return r[ROW_BITS-1:0];
    endfunction

    function automatic logic [SCREEN_BITS-1:0] current_screen_column();
        logic [SCREEN_BITS:0] s;
        s = (SCREEN_BITS+1)'(shadow_cfg.column_offset) + (SCREEN_BITS+1)'(cur_column);
        return (s > (SCREEN_BITS+1)'(SCREEN_MAX)) ? SCREEN_MAX : s[SCREEN_BITS-1:0];
    endfunction

    task automatic reset_predictor();
        shadow_cfg = default_config();
        run_max    = RANGE_MIN_RST;
        run_min    = RANGE_MAX_RST;
        phase_acc  = '0;
        cur_column = '0;
        prev_lower = '0;
        prev_upper = '0;
        prev_valid = 1'b0;
        trig_done  = 1'b0;
    endtask

    // Fold one accepted sample into the predicted trace; queue any point it emits
    task automatic decimate_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                   input logic [INDEX_BITS-1:0] index,
                                   input logic is_first, input logic is_last);
        logic signed [SAMPLE_BITS-1:0] v;
        logic signed [SAMPLE_BITS-1:0] rmin;
        logic signed [SAMPLE_BITS-1:0] rmax;
        logic [ACC_BITS:0]             acc_sum;
        logic [IPART_BITS-1:0]         ipart;
        logic [COLUMN_BITS-1:0]        col;
        trace_point_t                  pt;
        rmin = $signed(shadow_cfg.range_min);
        rmax = $signed(shadow_cfg.range_max);
        if (is_first)
        begin
            run_max    = rmin;
            run_min    = rmax;
            phase_acc  = '0;
            cur_column = '0;
            prev_valid = 1'b0;
            trig_done  = 1'b0;
        end
        // clamp low first, then high, so range_max wins on an inverted range
        v = value;
        if (v < rmin)
            v = rmin;
        if (v > rmax)
            v = rmax;
        if (v > run_max)
            run_max = v;
        if (v < run_min)
            run_min = v;
        acc_sum   = {1'b0, phase_acc} + (ACC_BITS+1)'(shadow_cfg.phase_step);
        phase_acc = (acc_sum > {1'b0, ACC_SAT}) ? ACC_SAT : acc_sum[ACC_BITS-1:0];
        ipart     = phase_acc[ACC_BITS-1:FRAC_BITS];
        col       = (ipart > IPART_BITS'(COL_SAT)) ? COL_SAT : ipart[COLUMN_BITS-1:0];
        pt = '{kind: KIND_COLUMN, column: '0, lower: '0, upper: '0, span: 1'b0,
               conn: CONN_NONE, from_row: '0, trig: 1'b0};
        if (col > cur_column)
        begin
            pt.column = current_screen_column();
            pt.lower  = map_row(run_min);
            pt.upper  = map_row(run_max);
            pt.span   = (pt.lower != pt.upper);
            if (!trig_done && index >= shadow_cfg.trigger_position)
            begin
                pt.trig   = 1'b1;
                trig_done = 1'b1;
            end
            if (prev_valid)
            begin
                if (pt.lower < prev_upper)
                begin
                    pt.conn     = CONN_RISING;
                    pt.from_row = prev_upper;
                end
                else if (pt.upper > prev_lower || !pt.span)
                begin
                    pt.conn     = CONN_FALLING;
                    pt.from_row = prev_lower;
                end
            end
            // sweep ends on a column with no mark yet: the column carries it
            if (is_last && !trig_done)
            begin
                pt.trig   = 1'b1;
                trig_done = 1'b1;
            end
            pending_points.push_back(pt);
            prev_lower = pt.lower;
            prev_upper = pt.upper;
            prev_valid = 1'b1;
            run_max    = rmin;
            run_min    = rmax;
            cur_column = col;
        end
        else if (is_last && !trig_done)
        begin
            trig_done = 1'b1;
            pt.kind   = KIND_MARK;
            pt.column = current_screen_column();
            pt.trig   = 1'b1;
            pending_points.push_back(pt);
        end
    endtask

    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_failure($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic check_trace_point();
        trace_point_t want;
        if (pending_points.size() == 0)
        begin
            report_failure($sformatf("unexpected result, column %0d", screen_column));
            return;
        end
        want = pending_points.pop_front();
        check_field("result_kind", result_kind, want.kind);
        check_field("screen_column", screen_column, want.column);
        check_field("lower_row", lower_row, want.lower);
        check_field("upper_row", upper_row, want.upper);
        check_field("span_drawn", span_drawn, want.span);
        check_field("connector", connector, want.conn);
        check_field("connector_from_row", connector_from_row, want.from_row);
        check_field("trigger_here", trigger_here, want.trig);
    endtask

    // Result side: check each transfer, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (result_valid === 1'b1 && result_stall == 1'b0)
            check_trace_point();
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Send one sample; the predictor runs at the transfer edge
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic [INDEX_BITS-1:0] index,
                               input logic is_first, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= value;
        sample_index <= index;
        sweep_start  <= is_first;
        sweep_end    <= is_last;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        decimate_sample(value, index, is_first, is_last);
    endtask

    // Stop sending and wait for every expected point, then some extra cycles
    task automatic wait_idle(input int extra);
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    // Register write; valid is left high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PHASE_STEP:       shadow_cfg.phase_step       = data[STEP_BITS-1:0];
            CFG_TRIGGER_POSITION: shadow_cfg.trigger_position = data[INDEX_BITS-1:0];
            CFG_ROW_BASELINE:     shadow_cfg.row_baseline     = data[BASE_BITS-1:0];
            CFG_INVERT:           shadow_cfg.invert           = data[0];
            CFG_ROW_SCALE:        shadow_cfg.row_scale        = data[SCALE_BITS-1:0];
            CFG_RANGE_MIN:        shadow_cfg.range_min        = data[SAMPLE_BITS-1:0];
            CFG_RANGE_MAX:        shadow_cfg.range_max        = data[SAMPLE_BITS-1:0];
            CFG_COLUMN_OFFSET:    shadow_cfg.column_offset    = data[OFFSET_BITS-1:0];
            default: ;
        endcase
    endtask

    // Drain, then rewrite the whole register set
    task automatic program_registers(input cfg_t c);
        wait_idle(LATENCY_SLACK);
        write_reg(CFG_PHASE_STEP,       CFG_DATA_BITS'(c.phase_step));
        write_reg(CFG_TRIGGER_POSITION, CFG_DATA_BITS'(c.trigger_position));
        write_reg(CFG_ROW_BASELINE,     CFG_DATA_BITS'(c.row_baseline));
        write_reg(CFG_INVERT,           CFG_DATA_BITS'(c.invert));
        write_reg(CFG_ROW_SCALE,        CFG_DATA_BITS'(c.row_scale));
        write_reg(CFG_RANGE_MIN,        {17'd0, c.range_min});
        write_reg(CFG_RANGE_MAX,        {17'd0, c.range_max});
        write_reg(CFG_COLUMN_OFFSET,    CFG_DATA_BITS'(c.column_offset));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        logic signed [SAMPLE_BITS-1:0] a;
        logic signed [SAMPLE_BITS-1:0] b;
        case ($urandom_range(5))
            0:       c.phase_step = 25'd1;
            1:       c.phase_step = 25'h1000000;
            2:       c.phase_step = 25'($urandom_range(200000, 4000000));
            default: c.phase_step = 25'($urandom_range(6000, 140000));
        endcase
        case ($urandom_range(3))
            0:       c.trigger_position = '0;
            1:       c.trigger_position = '1;
            default: c.trigger_position = 24'($urandom);
        endcase
        case ($urandom_range(3))
            0:       c.row_baseline = '0;
            1:       c.row_baseline = '1;
            default: c.row_baseline = 10'($urandom);
        endcase
        c.invert = 1'($urandom);
        case ($urandom_range(4))
            0:       c.row_scale = '0;
            1:       c.row_scale = '1;
            2:       c.row_scale = 24'($urandom);
            default: c.row_scale = 24'($urandom_range(20000, 300000));
        endcase
        a = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(4))
            0:
            begin
                c.range_min = -8'sd128;
                c.range_max = 8'sd127;
            end
            1:
            begin
                // inverted range
                c.range_min = (a > b) ? a : b;
                c.range_max = (a > b) ? b : a;
            end
            default:
            begin
                c.range_min = (a < b) ? a : b;
                c.range_max = (a < b) ? b : a;
            end
        endcase
        case ($urandom_range(3))
            0:       c.column_offset = '0;
            1:       c.column_offset = '1;
            default: c.column_offset = 10'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return -8'sd128;
            1:       return 8'sd127;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly whole sweeps around the trigger point; some run-on items and noise
    task automatic random_traffic(input int n_items);
        int sent;
        int len;
        int choice;
        int lead;
        logic [INDEX_BITS-1:0] base;
        sent = 0;
        while (sent < n_items)
        begin
            len    = $urandom_range(1, 40);
            choice = $urandom_range(99);
            lead   = $urandom_range(0, len);
            if ($urandom_range(3) == 0)
                base = 24'($urandom);
            else if (shadow_cfg.trigger_position > INDEX_BITS'(lead))
                base = shadow_cfg.trigger_position - INDEX_BITS'(lead);
            else
                base = '0;
            if ($urandom_range(29) == 0)
                wait_idle(0);
            if (choice < 80)
            begin
                for (int i = 0; i < len; i++)
                    send_sample(random_sample(), base + INDEX_BITS'(i), i == 0, i == len - 1);
            end
            else if (choice < 90)
            begin
                // carries on after the end with the kept state
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_sample(random_sample(), base + INDEX_BITS'(i), 1'b0,
                                1'($urandom_range(3) == 0));
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_sample(random_sample(), 24'($urandom), 1'($urandom), 1'($urandom));
            end
            sent += len;
        end
    endtask

    // Reset values: column per sample, clamping at the extremes, trigger at index 0
    task automatic test_reset_defaults();
        send_sample(8'sd127,  24'd0, 1'b1, 1'b0);
        send_sample(-8'sd128, 24'd1, 1'b0, 1'b0);
        send_sample(8'sd0,    24'd2, 1'b0, 1'b0);
        send_sample(-8'sd1,   24'd3, 1'b0, 1'b0);
        send_sample(8'sd5,    24'd4, 1'b0, 1'b0);
        send_sample(-8'sd60,  24'd5, 1'b0, 1'b1);
    endtask

    // Sweep that ends with no column and no trigger yet, so a trailing mark shows, then items past the end
    task automatic test_trailing_mark();
        cfg_t c;
        c = default_config();
        c.phase_step       = 25'd1;
        c.trigger_position = '1;
        program_registers(c);
        send_sample(8'sd10,  24'd100, 1'b1, 1'b0);
        send_sample(-8'sd10, 24'd101, 1'b0, 1'b0);
        send_sample(8'sd3,   24'd102, 1'b0, 1'b1);
        send_sample(8'sd4,   24'd103, 1'b0, 1'b0);
        send_sample(8'sd5,   24'd104, 1'b0, 1'b1);
    endtask

    // Last item lands on a column; then a trigger reached on a column at the top sample index
    task automatic test_end_on_column();
        cfg_t c;
        c = default_config();
        c.phase_step       = 25'd32768;
        c.trigger_position = '1;
        program_registers(c);
        send_sample(8'sd20,  24'd0, 1'b1, 1'b0);
        send_sample(8'sd40,  24'd1, 1'b0, 1'b0);
        send_sample(-8'sd20, 24'd2, 1'b0, 1'b0);
        send_sample(-8'sd40, 24'd3, 1'b0, 1'b1);
        send_sample(8'sd1,   24'hFFFFFC, 1'b1, 1'b0);
        send_sample(8'sd90,  24'hFFFFFD, 1'b0, 1'b0);
        send_sample(-8'sd90, 24'hFFFFFE, 1'b0, 1'b0);
        send_sample(8'sd0,   24'hFFFFFF, 1'b0, 1'b1);
    endtask

    // Inverted range, row saturation both ways, and zero scale with no span
    task automatic test_range_and_rows();
        cfg_t c;
        c = default_config();
        c.range_min     = 8'sd40;
        c.range_max     = -8'sd40;
        c.invert        = 1'b1;
        c.row_baseline  = '1;
        c.row_scale     = '1;
        c.column_offset = '1;
        program_registers(c);
        send_sample(8'sd127,  24'd0, 1'b1, 1'b0);
        send_sample(-8'sd128, 24'd1, 1'b0, 1'b1);
        c.invert       = 1'b0;
        c.row_baseline = '0;
        program_registers(c);
        send_sample(8'sd0,    24'd0, 1'b1, 1'b0);
        send_sample(8'sd127,  24'd1, 1'b0, 1'b1);
        c.range_min = -8'sd128;
        c.range_max = 8'sd127;
        c.row_scale = '0;
        program_registers(c);
        send_sample(-8'sd128, 24'd0, 1'b1, 1'b0);
        send_sample(8'sd127,  24'd1, 1'b0, 1'b0);
        send_sample(8'sd0,    24'd2, 1'b0, 1'b1);
    endtask

    // Step of 2^24: column counter saturates, screen column saturates past 8191
    task automatic test_column_saturation();
        cfg_t c;
        c = default_config();
        c.phase_step    = 25'h1000000;
        c.column_offset = '1;
        program_registers(c);
        for (int i = 0; i < 36; i++)
            send_sample(random_sample(), 24'(i), i == 0, i == 35);
    endtask

    task automatic random_phases();
        for (int p = 0; p < 3; p++)
        begin
            program_registers(random_config());
            random_traffic(30);
        end
    endtask

    task automatic test_random_slow_sender();
        send_idle_pct = 34;
        recv_idle_pct = 48;
        random_phases();
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct = 48;
        recv_idle_pct = 34;
        random_phases();
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phases();
    endtask

    // Sequence
    initial
    begin
        reset_predictor();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_trailing_mark();
        test_end_on_column();
        test_range_and_rows();
        test_column_saturation();
        test_random_slow_sender();
        test_random_slow_receiver();
        test_random_full_rate();
        wait_idle(LATENCY_SLACK);
        if (pending_points.size() != 0)
            report_failure($sformatf("%0d expected points never arrived",
                                     pending_points.size()));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mtd_pkg.sv
rtl/core/mtd_cfg.sv
rtl/core/mtd_front.sv
rtl/core/mtd_scale.sv
rtl/core/mtd_rowmap.sv
rtl/core/minmax_trace_decimator_top.sv
rtl/core/mtd_checker.sv
tb/sv/tb_minmax_trace_decimator_top.sv
